// ===== rtl/sdr_stream_deframer_alaw_unit_defines.svh =====
// Assertion macros shared by the deframer RTL files.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef SDR_STREAM_DEFRAMER_ALAW_UNIT_DEFINES_SVH
`define SDR_STREAM_DEFRAMER_ALAW_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDRDFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDRDFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== rtl/sdrdfa_pkg.sv =====
// Package of the stream deframer: types, codes and default sizes.
// Used by every module of the deframer; depends on nothing else.
`timescale 1ns / 1ps

package sdrdfa_pkg;

    localparam int SPECTRUM_HEADER_BYTES_DEF = 15;
    localparam int AUDIO_HEADER_BYTES_DEF    = 5;
    localparam int MAX_AUDIO_SAMPLES_DEF     = 2048;
    localparam int QUEUE_DEPTH_DEF           = 4;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;
    localparam int CNT_W = 16;

    // Configuration register indexes.
    localparam logic [0:0] REG_SPECTRUM_CODE = 1'b0;
    localparam logic [0:0] REG_AUDIO_CODE    = 1'b1;

    // Result kinds as they appear on the output tuser.
    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_BIN    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [1:0] {
        PKT_IDLE  = 2'd0,
        PKT_SPEC  = 2'd1,
        PKT_AUDIO = 2'd2
    } pkt_kind_t;

    // Work handed from the parser to the result stage.
    typedef enum logic [1:0] {
        OP_AUDIO   = 2'd0,
        OP_BIN     = 2'd1,
        OP_BIN_END = 2'd2,
        OP_STATUS  = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  rssi;
        logic [31:0] rate;
    } op_t;

endpackage

// ===== rtl/sdrdfa_front.sv =====
// Packet parser: tracks header and payload position, holds the type codes
// and turns each accepted byte into at most one queued request. Uses sdrdfa_pkg.
`timescale 1ns / 1ps

module sdrdfa_front #(
    parameter int SPECTRUM_HEADER_BYTES = sdrdfa_pkg::SPECTRUM_HEADER_BYTES_DEF,
    parameter int AUDIO_HEADER_BYTES    = sdrdfa_pkg::AUDIO_HEADER_BYTES_DEF,
    parameter int MAX_AUDIO_SAMPLES     = sdrdfa_pkg::MAX_AUDIO_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              q_full,
    output logic              push,
    output sdrdfa_pkg::op_t   push_op
);

    localparam logic [sdrdfa_pkg::POS_W-1:0] SPEC_HDR =
        sdrdfa_pkg::POS_W'(SPECTRUM_HEADER_BYTES);
    localparam logic [sdrdfa_pkg::POS_W-1:0] AUDIO_HDR =
        sdrdfa_pkg::POS_W'(AUDIO_HEADER_BYTES);
    localparam logic [sdrdfa_pkg::CNT_W-1:0] MAX_SAMPLES =
        sdrdfa_pkg::CNT_W'(MAX_AUDIO_SAMPLES);

    sdrdfa_pkg::pkt_kind_t              kind_reg, kind_next;
    logic [sdrdfa_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [sdrdfa_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [7:0]                         rssi_reg, rssi_next;
    logic [31:0]                        rate_reg, rate_next;
    logic [sdrdfa_pkg::CNT_W-1:0]       emitted_reg, emitted_next;
    logic [7:0]                         spec_code_reg;
    logic [7:0]                         audio_code_reg;

    logic                               accept;
    logic [sdrdfa_pkg::POS_W-1:0]       hdr_len;
    logic [sdrdfa_pkg::POS_W-1:0]       pos_inc;
    logic [sdrdfa_pkg::POS_W-1:0]       total;
    logic                               pkt_last;

    assign s_tready  = ~q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_code_reg  <= 8'd0;
            audio_code_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdrdfa_pkg::REG_SPECTRUM_CODE: spec_code_reg  <= cfg_data;
                sdrdfa_pkg::REG_AUDIO_CODE:    audio_code_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= sdrdfa_pkg::PKT_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            rssi_reg    <= '0;
            rate_reg    <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            kind_reg    <= kind_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            rssi_reg    <= rssi_next;
            rate_reg    <= rate_next;
            emitted_reg <= emitted_next;
        end
    end

    assign hdr_len  = (kind_reg == sdrdfa_pkg::PKT_SPEC) ? SPEC_HDR : AUDIO_HDR;
    assign pos_inc  = pos_reg + sdrdfa_pkg::POS_W'(1);
    assign total    = hdr_len + sdrdfa_pkg::POS_W'(len_reg);
    assign pkt_last = (pos_inc >= total);

    always_comb
    begin
        kind_next    = kind_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        rssi_next    = rssi_reg;
        rate_next    = rate_reg;
        emitted_next = emitted_reg;
        push         = 1'b0;
        push_op.kind = sdrdfa_pkg::OP_AUDIO;
        push_op.data = s_tdata;
        push_op.last = 1'b0;

        if (accept)
        begin
            unique case (kind_reg)
                sdrdfa_pkg::PKT_IDLE:
                begin
                    // Bytes that match neither code are dropped to resync.
                    priority if (s_tdata == spec_code_reg)
                        kind_next = sdrdfa_pkg::PKT_SPEC;
                    else if (s_tdata == audio_code_reg)
                        kind_next = sdrdfa_pkg::PKT_AUDIO;
                    else
                        kind_next = sdrdfa_pkg::PKT_IDLE;
                    if (s_tdata == spec_code_reg || s_tdata == audio_code_reg)
                    begin
                        pos_next     = sdrdfa_pkg::POS_W'(1);
                        len_next     = '0;
                        rssi_next    = '0;
                        rate_next    = '0;
                        emitted_next = '0;
                    end
                end
                sdrdfa_pkg::PKT_SPEC, sdrdfa_pkg::PKT_AUDIO:
                begin
                    pos_next = pos_inc;
                    if (pos_reg < hdr_len)
                    begin
                        if (pos_reg == sdrdfa_pkg::POS_W'(3))
                            len_next = {s_tdata, len_reg[7:0]};
                        else if (pos_reg == sdrdfa_pkg::POS_W'(4))
                            len_next = {len_reg[15:8], s_tdata};
                        if (kind_reg == sdrdfa_pkg::PKT_SPEC)
                        begin
                            if (pos_reg == sdrdfa_pkg::POS_W'(6))
                                rssi_next = s_tdata;
                            else if (pos_reg >= sdrdfa_pkg::POS_W'(9)
                                     && pos_reg <= sdrdfa_pkg::POS_W'(12))
                                rate_next = {rate_reg[23:0], s_tdata};
                        end
                        // An empty payload ends the packet on its last header byte.
                        if (pos_inc == hdr_len && len_next == '0)
                        begin
                            if (kind_reg == sdrdfa_pkg::PKT_SPEC)
                            begin
                                push         = 1'b1;
                                push_op.kind = sdrdfa_pkg::OP_STATUS;
                                push_op.last = 1'b1;
                            end
                            kind_next = sdrdfa_pkg::PKT_IDLE;
                            pos_next  = '0;
                        end
                    end
                    else
                    begin
                        if (kind_reg == sdrdfa_pkg::PKT_AUDIO)
                        begin
                            if (emitted_reg < MAX_SAMPLES)
                            begin
                                emitted_next = emitted_reg + sdrdfa_pkg::CNT_W'(1);
                                push         = 1'b1;
                                push_op.kind = sdrdfa_pkg::OP_AUDIO;
                                push_op.last = pkt_last || (emitted_next == MAX_SAMPLES);
                            end
                        end
                        else
                        begin
                            push         = 1'b1;
                            push_op.kind = pkt_last ? sdrdfa_pkg::OP_BIN_END
                                                    : sdrdfa_pkg::OP_BIN;
                        end
                        if (pkt_last)
                        begin
                            kind_next = sdrdfa_pkg::PKT_IDLE;
                            pos_next  = '0;
                        end
                    end
                end
                default:
                begin
                    kind_next = sdrdfa_pkg::PKT_IDLE;
                    pos_next  = '0;
                end
            endcase
        end

        push_op.rssi = rssi_next;
        push_op.rate = rate_next;
    end

endmodule

// ===== rtl/sdrdfa_queue.sv =====
// Short request queue between the parser and the result stage.
// Register-based ring with a fill count; uses sdrdfa_pkg for the entry type.
`timescale 1ns / 1ps
`include "sdr_stream_deframer_alaw_unit_defines.svh"

module sdrdfa_queue #(
    parameter int DEPTH = sdrdfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sdrdfa_pkg::op_t  push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sdrdfa_pkg::op_t  head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sdrdfa_pkg::op_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    `SDRDFA_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= FULL_CNT)
    `SDRDFA_ASSERT_IMPL(a_no_lost_push, clk, rst_n, push, !full)
    `SDRDFA_ASSERT_NEXT(a_cnt_grows, clk, rst_n, do_push && !do_pop, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `SDRDFA_ASSERT_IMPL(a_ptr_gap, clk, rst_n, cnt_reg == '0 || cnt_reg == FULL_CNT, wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== rtl/sdrdfa_back.sv =====
// Result stage: expands queued requests into output items, decodes A-law
// samples and holds the output register. Uses sdrdfa_pkg.
`timescale 1ns / 1ps
`include "sdr_stream_deframer_alaw_unit_defines.svh"

module sdrdfa_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  sdrdfa_pkg::op_t  head_op,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // audio_sample[15:0], bin_value[23:16],
                                        // signal_strength[31:24], spectrum_rate[63:32]
    output logic [1:0]       m_tuser,   // result_kind[1:0]
    output logic             m_tlast    // last_of_packet
);

    function automatic logic [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [14:0] mag;
        a   = code ^ 8'h55;
        seg = a[6:4];
        mag = {7'd0, a[3:0], 4'd0};
        if (seg == 3'd0)
            mag = mag + 15'd8;
        else
            mag = (mag + 15'h108) << (seg - 3'd1);
        alaw_expand = a[7] ? {1'b0, mag} : 16'd0 - {1'b0, mag};
    endfunction

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic [15:0]        out_sample_reg, out_sample_next;
    logic [7:0]         out_bin_reg, out_bin_next;
    logic [7:0]         out_rssi_reg, out_rssi_next;
    logic [31:0]        out_rate_reg, out_rate_next;
    logic               out_last_reg, out_last_next;
    logic               phase_reg, phase_next;
    logic               can_load;

    assign can_load = ~out_valid_reg | m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_sample_next = out_sample_reg;
        out_bin_next    = out_bin_reg;
        out_rssi_next   = out_rssi_reg;
        out_rate_next   = out_rate_reg;
        out_last_next   = out_last_reg;
        phase_next      = phase_reg;
        pop             = 1'b0;

        if (can_load)
        begin
            out_valid_next  = head_valid;
            out_sample_next = '0;
            out_bin_next    = '0;
            out_rssi_next   = '0;
            out_rate_next   = '0;
            out_last_next   = 1'b0;
            if (head_valid)
            begin
                unique case (head_op.kind)
                    sdrdfa_pkg::OP_AUDIO:
                    begin
                        out_kind_next   = sdrdfa_pkg::KIND_AUDIO;
                        out_sample_next = alaw_expand(head_op.data);
                        out_last_next   = head_op.last;
                        pop             = 1'b1;
                    end
                    sdrdfa_pkg::OP_BIN:
                    begin
                        out_kind_next = sdrdfa_pkg::KIND_BIN;
                        out_bin_next  = head_op.data;
                        pop           = 1'b1;
                    end
                    sdrdfa_pkg::OP_BIN_END:
                    begin
                        // The final bin goes out first, then the status item.
                        if (!phase_reg)
                        begin
                            out_kind_next = sdrdfa_pkg::KIND_BIN;
                            out_bin_next  = head_op.data;
                            phase_next    = 1'b1;
                        end
                        else
                        begin
                            out_kind_next = sdrdfa_pkg::KIND_STATUS;
                            out_rssi_next = head_op.rssi;
                            out_rate_next = head_op.rate;
                            out_last_next = 1'b1;
                            phase_next    = 1'b0;
                            pop           = 1'b1;
                        end
                    end
                    sdrdfa_pkg::OP_STATUS:
                    begin
                        out_kind_next = sdrdfa_pkg::KIND_STATUS;
                        out_rssi_next = head_op.rssi;
                        out_rate_next = head_op.rate;
                        out_last_next = 1'b1;
                        pop           = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            out_kind_reg  <= sdrdfa_pkg::KIND_AUDIO;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_bin_reg    <= out_bin_next;
        out_rssi_reg   <= out_rssi_next;
        out_rate_reg   <= out_rate_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rate_reg, out_rssi_reg, out_bin_reg, out_sample_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `SDRDFA_ASSERT_IMPL(a_phase_op, clk, rst_n, phase_reg, head_valid && head_op.kind == sdrdfa_pkg::OP_BIN_END)
    `SDRDFA_ASSERT_IMPL(a_phase_bin, clk, rst_n, $rose(phase_reg), out_valid_reg && out_kind_reg == sdrdfa_pkg::KIND_BIN && !out_last_reg)
    `SDRDFA_ASSERT_IMPL(a_pop_loads, clk, rst_n, pop, can_load && head_valid)
    `SDRDFA_ASSERT_IMPL(a_bin_not_last, clk, rst_n, out_valid_reg && out_kind_reg == sdrdfa_pkg::KIND_BIN, !out_last_reg)

endmodule

// ===== rtl/sdr_stream_deframer_alaw_unit.sv =====
// Each accepted byte's request is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue has room; each byte gives at most one queued
// request, and the last payload byte of a spectrum packet gives two results, bin then status.
// The request queue absorbs that extra item and output stalls; s_tready falls only when full.
// Reset (rst_n, asynchronous, active low) clears the parser to idle, empties the queue and
// output register, and sets the spectrum type code to 0 and the audio type code to 1.
`timescale 1ns / 1ps

module sdr_stream_deframer_alaw_unit #(
    parameter int SPECTRUM_HEADER_BYTES = sdrdfa_pkg::SPECTRUM_HEADER_BYTES_DEF,
    parameter int AUDIO_HEADER_BYTES    = sdrdfa_pkg::AUDIO_HEADER_BYTES_DEF,
    parameter int MAX_AUDIO_SAMPLES     = sdrdfa_pkg::MAX_AUDIO_SAMPLES_DEF,
    parameter int QUEUE_DEPTH           = sdrdfa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // audio_sample[15:0], bin_value[23:16],
                                    // signal_strength[31:24], spectrum_rate[63:32]
    output logic [1:0]  m_tuser,    // result_kind[1:0]
    output logic        m_tlast,    // last_of_packet
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic             push;
    sdrdfa_pkg::op_t  push_op;
    logic             q_full;
    logic             pop;
    logic             head_valid;
    sdrdfa_pkg::op_t  head_op;

    sdrdfa_front #(
        .SPECTRUM_HEADER_BYTES (SPECTRUM_HEADER_BYTES),
        .AUDIO_HEADER_BYTES    (AUDIO_HEADER_BYTES),
        .MAX_AUDIO_SAMPLES     (MAX_AUDIO_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    sdrdfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    sdrdfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
